// File: hdl/token_reorder_buffer_top_macros.svh
// Assertion helpers for the reorder buffer RTL.
`ifndef TOKEN_REORDER_BUFFER_TOP_MACROS_SVH
`define TOKEN_REORDER_BUFFER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

`define TRB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define TRB_ASSERT(label, clk, rst_n, prop)

`define TRB_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hdl/tkrob_pkg.sv
`timescale 1ns / 1ps

package tkrob_pkg;

    localparam int OP_W        = 2;
    localparam int TOKEN_W     = 8;
    localparam int DATA_PORT_W = 64;
    localparam int DEST_W      = 16;
    localparam int CFG_W       = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_ISSUE = 2'd0;
    localparam logic [OP_W-1:0] OP_REPLY = 2'd1;
    localparam logic [OP_W-1:0] OP_PULL  = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic                   status;
        logic [TOKEN_W-1:0]     token;
        logic [DATA_PORT_W-1:0] data;
        logic [DEST_W-1:0]      dest;
    } t_rsp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/token_reorder_buffer_top.sv
`timescale 1ns / 1ps
// Reorder buffer for outstanding requests. Items enter on the input channel
// (i_in_valid / o_in_ready) with an op: issue tags a request with the next
// token, reply stores returned data under its token, pull hands back the
// reply at the head of issue order. Every item gives one result item on the
// output channel (o_out_valid / i_out_ready) with a status and payload.
// Issue, reply and unknown ops are resolved combinationally and their result is
// visible in the cycle after acceptance. A pull first reads the slot store, a
// synchronous memory, and the present bit is tested on the registered read
// data before the result is pushed into the output buffer.
// Results queue in a two-entry output buffer, so input items keep being
// taken while a result waits; once both entries are held by a stalled
// receiver, o_in_ready stays low until one is taken.
// After reset the present map is swept clear, one slot per cycle, with
// o_in_ready low. A capacity write (i_cfg_we) reduces the head pointer by a
// bit-serial remainder unit, holding o_in_ready low until the unit is done.
`include "token_reorder_buffer_top_macros.svh"

module token_reorder_buffer_top import tkrob_pkg::*; #(
    parameter int unsigned SLOTS      = 256,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [OP_W-1:0]        i_op,
    input  logic [DATA_PORT_W-1:0] i_item_data,
    input  logic [DEST_W-1:0]      i_dest_node,
    input  logic [TOKEN_W-1:0]     i_reply_token,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_status,
    output logic [TOKEN_W-1:0]     o_out_token,
    output logic [DATA_PORT_W-1:0] o_out_data,
    output logic [DEST_W-1:0]      o_out_dest,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = CW + 1;
    localparam int TW = (CW > TOKEN_W) ? CW : TOKEN_W;

    function automatic logic [CW-1:0] f_eff_cap(input logic [CFG_W-1:0] v);
        logic [CW-1:0] c;
        if (v == '0) begin
            c = CW'(1);
        end else if (32'(v) > SLOTS) begin
            c = CW'(SLOTS);
        end else begin
            c = CW'(v);
        end
        return c;
    endfunction

    logic [AW-1:0]         r_await;
    logic [AW-1:0]         r_await_eff;
    logic [CW-1:0]         r_inflight;
    logic [CW-1:0]         r_eff_cap;
    logic                  r_cap_pend;
    logic                  r_pull_pend;

    logic                  in_acc;
    logic                  issue_full;
    logic [SW-1:0]         issue_sum;
    logic [AW-1:0]         issue_slot;
    logic                  reply_hit;
    logic [AW-1:0]         pull_next;
    logic                  mod_start;
    logic                  mod_busy;
    logic                  mod_done;
    logic [AW-1:0]         mod_result;
    logic                  mem_clearing;
    logic                  mem_rd_en;
    logic                  mem_rd_present;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic                  pres_we;
    logic                  pres_wbit;
    logic                  data_we;
    logic [AW-1:0]         wr_addr;
    logic                  q_push;
    t_rsp                  q_rsp;
    t_rsp                  q_head;
    t_q_status             q_stat;

    assign in_acc = i_in_valid && o_in_ready;

    assign o_in_ready = !mem_clearing && !r_pull_pend && !r_cap_pend && !mod_busy &&
                        !mod_done && !q_stat.full;

    assign issue_full = (SW'(r_inflight) + SW'(1)) >= SW'(r_eff_cap);
    assign issue_sum  = SW'(r_await_eff) + SW'(r_inflight);
    assign issue_slot = (issue_sum >= SW'(r_eff_cap)) ? AW'(issue_sum - SW'(r_eff_cap))
                                                       : AW'(issue_sum);
    assign reply_hit  = TW'(i_reply_token) < TW'(r_eff_cap);
    assign pull_next  = ((CW'(r_await_eff) + CW'(1)) == r_eff_cap) ? '0
                                                                 : r_await_eff + AW'(1);

    assign mod_start = r_cap_pend && !mod_busy;

    assign mem_rd_en = in_acc && (i_op == OP_PULL);
    assign data_we   = in_acc && (i_op == OP_REPLY) && reply_hit;
    assign pres_we   = data_we || (r_pull_pend && mem_rd_present);
    assign pres_wbit = !r_pull_pend;
    assign wr_addr   = r_pull_pend ? r_await_eff : AW'(i_reply_token);

    always_comb begin
        q_rsp  = '0;
        q_push = 1'b0;
        if (r_pull_pend) begin
            q_push = 1'b1;
            if (mem_rd_present) begin
                q_rsp.status = ST_OK;
                q_rsp.data   = DATA_PORT_W'(mem_rd_data);
            end else begin
                q_rsp.status = ST_FAIL;
            end
        end else if (in_acc) begin
            q_push = 1'b1;
            unique case (i_op)
                OP_ISSUE: begin
                    if (issue_full) begin
                        q_rsp.status = ST_FAIL;
                    end else begin
                        q_rsp.status = ST_OK;
                        q_rsp.token  = TOKEN_W'(issue_slot);
                        q_rsp.data   = DATA_PORT_W'(i_item_data[DATA_WIDTH-1:0]);
                        q_rsp.dest   = i_dest_node;
                    end
                end
                OP_REPLY: begin
                    q_rsp.status = ST_OK;
                end
                OP_PULL: begin
                    q_push = 1'b0;
                end
                default: begin
                    q_rsp.status = ST_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await     <= '0;
            r_await_eff <= '0;
            r_inflight  <= '0;
            r_eff_cap   <= f_eff_cap(CFG_RESET);
            r_cap_pend  <= 1'b0;
            r_pull_pend <= 1'b0;
        end else begin
            r_pull_pend <= mem_rd_en;
            if (i_cfg_we) begin
                r_eff_cap  <= f_eff_cap(i_cfg_wdata);
                r_cap_pend <= 1'b1;
            end else if (mod_start) begin
                r_cap_pend <= 1'b0;
            end
            if (mod_done && !r_cap_pend) begin
                r_await_eff <= mod_result;
            end
            if (in_acc && (i_op == OP_ISSUE) && !issue_full) begin
                r_inflight <= r_inflight + CW'(1);
            end
            if (r_pull_pend && mem_rd_present) begin
                r_await     <= pull_next;
                r_await_eff <= pull_next;
                if (r_inflight != '0) begin
                    r_inflight <= r_inflight - CW'(1);
                end
            end
        end
    end

    tkrob_mod_unit #(
        .SLOTS (SLOTS)
    ) u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_await),
        .i_divisor  (r_eff_cap),
        .o_busy     (mod_busy),
        .o_done     (mod_done),
        .o_result   (mod_result)
    );

    tkrob_slot_mem #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_slot_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (mem_rd_en),
        .i_rd_addr    (r_await_eff),
        .i_wr_addr    (wr_addr),
        .i_pres_we    (pres_we),
        .i_pres_wbit  (pres_wbit),
        .i_data_we    (data_we),
        .i_wr_data    (i_item_data[DATA_WIDTH-1:0]),
        .o_rd_present (mem_rd_present),
        .o_rd_data    (mem_rd_data),
        .o_clearing   (mem_clearing)
    );

    tkrob_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rsp   (q_rsp),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_rsp   (q_head),
        .o_stat  (q_stat)
    );

    assign o_status    = q_head.status;
    assign o_out_token = q_head.token;
    assign o_out_data  = q_head.data;
    assign o_out_dest  = q_head.dest;

    // A pull resolves in the cycle after its memory read.
    `TRB_ASSERT(a_pull_one_cycle, i_clk, i_rst_n, r_pull_pend |=> !r_pull_pend)
    // Once no capacity change is in progress the head pointer lies below capacity.
    `TRB_ASSERT(a_head_in_range, i_clk, i_rst_n,
        (!r_cap_pend && !mod_busy && !mod_done) |-> (CW'(r_await_eff) < r_eff_cap))
    // The in-flight count never reaches the number of slots.
    `TRB_ASSERT(a_inflight_bound, i_clk, i_rst_n, r_inflight < CW'(SLOTS))
    // A result is never pushed into a full output buffer.
    `TRB_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, q_push && q_stat.full)

endmodule

// File: hdl/tkrob_mod_unit.sv
`timescale 1ns / 1ps

module tkrob_mod_unit import tkrob_pkg::*; #(
    parameter int unsigned SLOTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(SLOTS)-1:0]     i_dividend,
    input  logic [$clog2(SLOTS+1)-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [$clog2(SLOTS)-1:0]     o_result
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int RW   = CW + 1;
    localparam int CNTW = $clog2(AW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_rem;
    logic [AW-1:0]   r_src;
    logic [CW-1:0]   r_div;
    logic [RW-1:0]   n_trial;
    logic [RW-1:0]   n_rem;

    always_comb begin
        n_trial = {r_rem[RW-2:0], r_src[AW-1]};
        if (n_trial >= RW'(r_div)) begin
            n_rem = n_trial - RW'(r_div);
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_src <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_src <= r_src << 1;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = AW'(r_rem);

endmodule

// File: hdl/tkrob_slot_mem.sv
`timescale 1ns / 1ps

module tkrob_slot_mem import tkrob_pkg::*; #(
    parameter int unsigned SLOTS      = 256,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]     i_rd_addr,
    input  logic [$clog2(SLOTS)-1:0]     i_wr_addr,
    input  logic                         i_pres_we,
    input  logic                         i_pres_wbit,
    input  logic                         i_data_we,
    input  logic [DATA_WIDTH-1:0]        i_wr_data,
    output logic                         o_rd_present,
    output logic [DATA_WIDTH-1:0]        o_rd_data,
    output logic                         o_clearing
);

    localparam int AW = $clog2(SLOTS);

    logic                  r_present_mem [SLOTS];
    logic [DATA_WIDTH-1:0] r_data_mem    [SLOTS];
    logic                  r_rd_present;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_clr_busy;
    logic [AW-1:0]         r_clr_addr;

    // After reset every present bit is swept to zero, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_present_mem[r_clr_addr] <= 1'b0;
        end else if (i_pres_we) begin
            r_present_mem[i_wr_addr] <= i_pres_wbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_present <= r_present_mem[i_rd_addr];
            r_rd_data    <= r_data_mem[i_rd_addr];
        end
    end

    assign o_rd_present = r_rd_present;
    assign o_rd_data    = r_rd_data;
    assign o_clearing   = r_clr_busy;

endmodule

// File: hdl/tkrob_out_queue.sv
`timescale 1ns / 1ps

module tkrob_out_queue import tkrob_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rsp      i_rsp,
    input  logic      i_ready,
    output logic      o_valid,
    output t_rsp      o_rsp,
    output t_q_status o_stat
);

    t_rsp       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       n_pop;

    assign n_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (n_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !n_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (n_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_rsp;
        end
    end

    assign o_valid      = (r_cnt != 2'd0);
    assign o_rsp        = r_q[r_rd_ptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule
